### rtl/lbm_pkg.sv
// ----------------------------------------------------------------------------
// D2Q9 BGK collision package
// Shared beat types, pipeline latencies and lattice constants.
// ----------------------------------------------------------------------------
package lbm_pkg;

  localparam int DW        = 24;
  localparam int RATE_W    = 22;
  localparam int RATE_FRAC = 20;
  localparam int N_DIR     = 9;
  localparam int MOM_W     = 27;
  localparam int DIV_QB    = 25;
  localparam int DIV_LAT   = DIV_QB + 2;
  localparam int SQ_LAT    = 2;
  localparam int LANE_LAT  = 9;
  localparam int UU_W      = 48;

  localparam logic [RATE_W-1:0] RATE_RESET = 22'd1048576;

  localparam logic [32:0] RECIP9    = 33'd7635497416;
  localparam int          RECIP_SH  = 36;
  localparam logic [32:0] BIAS9     = 33'd4831838208;
  localparam int          BIAS_SH   = 29;

  typedef logic signed [DW-1:0] sample_t;

  typedef struct packed {
    sample_t f_rest;
    sample_t f_n;
    sample_t f_ne;
    sample_t f_e;
    sample_t f_se;
    sample_t f_s;
    sample_t f_sw;
    sample_t f_w;
    sample_t f_nw;
  } in_t;

  typedef struct packed {
    sample_t g_rest;
    sample_t g_n;
    sample_t g_ne;
    sample_t g_e;
    sample_t g_se;
    sample_t g_s;
    sample_t g_sw;
    sample_t g_w;
    sample_t g_nw;
    sample_t density;
    sample_t vel_x;
    sample_t vel_y;
  } out_t;

  typedef enum logic [1:0] {
    WT_16,
    WT_4,
    WT_1
  } wt_e;

  localparam logic signed [1:0] CX [N_DIR] =
    '{2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] CY [N_DIR] =
    '{2'sd0, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam wt_e WT [N_DIR] =
    '{WT_16, WT_4, WT_1, WT_4, WT_1, WT_4, WT_1, WT_4, WT_1};

endpackage

### rtl/lbm_div.sv
// ----------------------------------------------------------------------------
// Pipelined velocity divider
// Floor division of momentum by density, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lbm_div #(
  parameter int FRAC_BITS = 20
) (
  input  logic                             clk_i,
  input  logic signed [lbm_pkg::MOM_W-1:0] num_i,
  input  lbm_pkg::sample_t                 den_i,
  output lbm_pkg::sample_t                 quo_o
);
  import lbm_pkg::*;

  localparam int NW = MOM_W + FRAC_BITS;
  localparam int CW = (NW + 1 > DW + DIV_QB) ? NW + 1 : DW + DIV_QB;
  localparam int QW = DIV_QB + 2;
  localparam logic signed [QW-1:0] Q_MAX = QW'(8388607);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(8388608);

  logic signed [NW-1:0] nsh;
  logic [NW-1:0]        mag;
  logic [CW-1:0]        mag_c;
  logic [CW-1:0]        den_c;
  logic                 neg_d;
  logic                 ovf_d;
  logic                 zero_d;

  logic [CW-1:0]        rem_q  [DIV_QB+1];
  logic [DIV_QB-1:0]    quo_q  [DIV_QB+1];
  logic [DW-2:0]        den_q  [DIV_QB];
  logic                 neg_q  [DIV_QB+1];
  logic                 ovf_q  [DIV_QB+1];
  logic                 zero_q [DIV_QB+1];

  logic [CW-1:0]        rem_n  [DIV_QB];
  logic [DIV_QB-1:0]    quo_n  [DIV_QB];

  logic signed [QW-1:0] qv;
  logic signed [QW-1:0] qinc;
  logic signed [QW-1:0] val;
  sample_t              quo_d;
  sample_t              quo_q_r;

  always_comb begin
    nsh    = NW'(num_i) <<< FRAC_BITS;
    neg_d  = num_i[MOM_W-1];
    mag    = neg_d ? NW'(-nsh) : NW'(nsh);
    mag_c  = CW'(mag);
    den_c  = CW'(den_i[DW-2:0]);
    zero_d = den_i[DW-1] || (den_i == '0);
    ovf_d  = mag_c >= (den_c << DIV_QB);
  end

  always_comb begin
    logic [CW:0] trial;
    for (int i = 0; i < DIV_QB; i++) begin
      trial    = {1'b0, rem_q[i]} - {1'b0, (CW'(den_q[i]) << (DIV_QB - 1 - i))};
      rem_n[i] = trial[CW] ? rem_q[i] : trial[CW-1:0];
      quo_n[i] = quo_q[i];
      quo_n[i][DIV_QB-1-i] = ~trial[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= mag_c;
    quo_q[0]  <= '0;
    den_q[0]  <= den_i[DW-2:0];
    neg_q[0]  <= neg_d;
    ovf_q[0]  <= ovf_d;
    zero_q[0] <= zero_d;
    for (int i = 0; i < DIV_QB; i++) begin
      rem_q[i+1]  <= rem_n[i];
      quo_q[i+1]  <= quo_n[i];
      if (i < DIV_QB - 1) begin
        den_q[i+1] <= den_q[i];
      end
      neg_q[i+1]  <= neg_q[i];
      ovf_q[i+1]  <= ovf_q[i];
      zero_q[i+1] <= zero_q[i];
    end
    quo_q_r <= quo_d;
  end

  always_comb begin
    qv   = $signed({2'b00, quo_q[DIV_QB]});
    qinc = qv + ((rem_q[DIV_QB] != '0) ? QW'(1) : QW'(0));
    val  = neg_q[DIV_QB] ? -qinc : qv;
    if (zero_q[DIV_QB]) begin
      quo_d = '0;
    end else if (ovf_q[DIV_QB]) begin
      quo_d = neg_q[DIV_QB] ? sample_t'(Q_MIN) : sample_t'(Q_MAX);
    end else if (val > Q_MAX) begin
      quo_d = sample_t'(Q_MAX);
    end else if (val < Q_MIN) begin
      quo_d = sample_t'(Q_MIN);
    end else begin
      quo_d = val[DW-1:0];
    end
  end

  assign quo_o = quo_q_r;

endmodule

### rtl/lbm_lane.sv
// ----------------------------------------------------------------------------
// Collision lane
// Equilibrium and relaxation for one lattice direction, fully pipelined.
// ----------------------------------------------------------------------------
module lbm_lane #(
  parameter int FRAC_BITS = 20
) (
  input  logic                               clk_i,
  input  logic signed [1:0]                  cx_i,
  input  logic signed [1:0]                  cy_i,
  input  lbm_pkg::wt_e                       wt_i,
  input  lbm_pkg::sample_t                   f_i,
  input  lbm_pkg::sample_t                   rho_i,
  input  lbm_pkg::sample_t                   ux_i,
  input  lbm_pkg::sample_t                   uy_i,
  input  logic [lbm_pkg::UU_W-1:0]           uu_i,
  input  logic [lbm_pkg::RATE_W-1:0]         rate_i,
  output lbm_pkg::sample_t                   g_o
);
  import lbm_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int PW   = (2 * F + 4 > 56) ? 2 * F + 4 : 56;
  localparam int PC   = F + 30;
  localparam int LO_W = 26;
  localparam int HI_W = PC - LO_W;
  localparam int PRW  = DW + PC + 1;
  localparam int TW   = 30;
  localparam int CPW  = DW + 1 + RATE_W + 1;

  localparam logic signed [PW-1:0]  P_HI = {{(PW-PC+1){1'b0}}, {(PC-1){1'b1}}};
  localparam logic signed [PW-1:0]  P_LO = {{(PW-PC+1){1'b1}}, {(PC-1){1'b0}}};
  localparam logic signed [PRW-1:0] T_HI = {{(PRW-TW+1){1'b0}}, {(TW-1){1'b1}}};
  localparam logic signed [PRW-1:0] T_LO = {{(PRW-TW+1){1'b1}}, {(TW-1){1'b0}}};
  localparam logic signed [31:0]    S_MAX = 32'sd8388607;
  localparam logic signed [31:0]    S_MIN = -32'sd8388608;
  localparam logic signed [29:0]    G_MAX = 30'sd8388607;
  localparam logic signed [29:0]    G_MIN = -30'sd8388608;

  logic signed [25:0]        cu_d, cu_q, cu2_q, tx, ty;
  logic signed [51:0]        cusq_q;
  logic signed [PW-1:0]      p2, ps;
  logic signed [PC-1:0]      p_d, p_q;
  logic signed [DW+LO_W:0]   pplo_q;
  logic signed [DW+HI_W-1:0] pphi_q;
  logic signed [PRW-1:0]     prod, ts;
  logic signed [TW-1:0]      t_d, t_q;
  logic signed [31:0]        z;
  logic [32:0]               yp;
  logic [65:0]               m_q;
  logic signed [31:0]        qf;
  sample_t                   feq;
  logic signed [DW:0]        diff_q;
  logic signed [CPW-1:0]     cprod_q, corr;
  logic signed [29:0]        gw;
  sample_t                   g_d, g_q;

  logic [UU_W-1:0] uu1_q, uu2_q;
  sample_t rho1_q, rho2_q, rho3_q;
  sample_t f1_q, f2_q, f3_q, f4_q, f5_q, f6_q, f7_q, f8_q;

  always_comb begin
    tx   = (cx_i == 2'sd1) ? 26'(ux_i) : ((cx_i == -2'sd1) ? -26'(ux_i) : '0);
    ty   = (cy_i == 2'sd1) ? 26'(uy_i) : ((cy_i == -2'sd1) ? -26'(uy_i) : '0);
    cu_d = tx + ty;
  end

  always_comb begin
    p2 = (PW'(2) <<< (2 * F)) + ((PW'(cu2_q) * 6) <<< F) + PW'(cusq_q) * 9
         - $signed(PW'(uu2_q)) * 3;
    ps = p2 >>> (F + 1);
    if (ps > P_HI) begin
      p_d = PC'(P_HI);
    end else if (ps < P_LO) begin
      p_d = PC'(P_LO);
    end else begin
      p_d = PC'(ps);
    end
  end

  always_comb begin
    prod = (PRW'(pphi_q) <<< LO_W) + PRW'(pplo_q);
    ts   = prod >>> F;
    if (ts > T_HI) begin
      t_d = TW'(T_HI);
    end else if (ts < T_LO) begin
      t_d = TW'(T_LO);
    end else begin
      t_d = TW'(ts);
    end
  end

  always_comb begin
    case (wt_i)
      WT_16:   z = 32'(t_q) <<< 2;
      WT_4:    z = 32'(t_q);
      WT_1:    z = 32'(t_q) >>> 2;
      default: z = '0;
    endcase
    yp = 33'(z) + BIAS9;
  end

  always_comb begin
    qf = $signed(32'(m_q[65:RECIP_SH])) - (32'sd1 <<< BIAS_SH);
    if (qf > S_MAX) begin
      feq = sample_t'(S_MAX);
    end else if (qf < S_MIN) begin
      feq = sample_t'(S_MIN);
    end else begin
      feq = qf[DW-1:0];
    end
  end

  always_comb begin
    corr = cprod_q >>> RATE_FRAC;
    gw   = 30'(f8_q) - 30'(corr);
    if (gw > G_MAX) begin
      g_d = sample_t'(G_MAX);
    end else if (gw < G_MIN) begin
      g_d = sample_t'(G_MIN);
    end else begin
      g_d = gw[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    cu_q    <= cu_d;
    uu1_q   <= uu_i;
    rho1_q  <= rho_i;
    f1_q    <= f_i;

    cusq_q  <= cu_q * cu_q;
    cu2_q   <= cu_q;
    uu2_q   <= uu1_q;
    rho2_q  <= rho1_q;
    f2_q    <= f1_q;

    p_q     <= p_d;
    rho3_q  <= rho2_q;
    f3_q    <= f2_q;

    pplo_q  <= rho3_q * $signed({1'b0, p_q[LO_W-1:0]});
    pphi_q  <= rho3_q * $signed(p_q[PC-1:LO_W]);
    f4_q    <= f3_q;

    t_q     <= t_d;
    f5_q    <= f4_q;

    m_q     <= yp * RECIP9;
    f6_q    <= f5_q;

    diff_q  <= (DW+1)'(f6_q) - (DW+1)'(feq);
    f7_q    <= f6_q;

    cprod_q <= diff_q * $signed({1'b0, rate_i});
    f8_q    <= f7_q;

    g_q     <= g_d;
  end

  assign g_o = g_q;

endmodule

### rtl/lbm_d2q9_bgk_collision.sv
// ----------------------------------------------------------------------------
// D2Q9 BGK collision
// Relaxes the nine distributions of one lattice cell toward equilibrium.
// ----------------------------------------------------------------------------
// A cell beat is taken on item_i at a clock edge with start high; busy is
// always low, so a new cell may follow in every cycle. Each cell returns one
// beat on result_o, marked by result_valid_o for a single cycle, via one
// input stage, a 27-stage divider resolving one quotient bit per inner
// stage, two squaring stages, nine parallel nine-stage collision lanes and
// one merging output register. Throughput is one cell per cycle; the
// receiver cannot stall and results are presented exactly once. The user
// writes the relaxation rate via relax_rate_we_i only while no cell is in
// flight (not enforced). Reset clears in-flight markers, sets rate to 1.0.
// ----------------------------------------------------------------------------
module lbm_d2q9_bgk_collision #(
  parameter int FRAC_BITS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  lbm_pkg::in_t                item_i,
  input  logic                        relax_rate_we_i,
  input  logic [lbm_pkg::RATE_W-1:0]  relax_rate_i,
  output lbm_pkg::out_t               result_o,
  output logic                        result_valid_o
);
  import lbm_pkg::*;

  localparam int DLY_A = DIV_LAT + SQ_LAT;
  localparam int TOTAL = 1 + DIV_LAT + SQ_LAT + LANE_LAT + 1;
  localparam logic signed [27:0] R_MAX = 28'sd8388607;
  localparam logic signed [27:0] R_MIN = -28'sd8388608;

  logic [RATE_W-1:0] rate_q;
  logic [TOTAL-1:0]  vld_q;

  logic signed [27:0]      rsum;
  sample_t                 rho_d, rho_q;
  logic signed [MOM_W-1:0] mx_d, mx_q, my_d, my_q;
  in_t                     in_q;

  in_t     fd_q   [DLY_A];
  sample_t rhod_q [DLY_A];
  sample_t ux, uy, ux1_q, uy1_q, ux2_q, uy2_q;
  logic signed [2*DW-1:0] sqx_q, sqy_q;
  logic [UU_W-1:0]        uu_q;

  sample_t od_rho_q [LANE_LAT];
  sample_t od_ux_q  [LANE_LAT];
  sample_t od_uy_q  [LANE_LAT];

  logic [N_DIR*DW-1:0] f_flat;
  logic [N_DIR*DW-1:0] g_flat;
  sample_t             g [N_DIR];
  out_t                result_q;

  assign busy = 1'b0;

  always_comb begin
    rsum = 28'(item_i.f_rest) + 28'(item_i.f_n) + 28'(item_i.f_ne) + 28'(item_i.f_e)
         + 28'(item_i.f_se) + 28'(item_i.f_s) + 28'(item_i.f_sw) + 28'(item_i.f_w)
         + 28'(item_i.f_nw);
    if (rsum > R_MAX) begin
      rho_d = sample_t'(R_MAX);
    end else if (rsum < R_MIN) begin
      rho_d = sample_t'(R_MIN);
    end else begin
      rho_d = rsum[DW-1:0];
    end
    mx_d = MOM_W'(item_i.f_ne) + MOM_W'(item_i.f_e) + MOM_W'(item_i.f_se)
         - MOM_W'(item_i.f_sw) - MOM_W'(item_i.f_w) - MOM_W'(item_i.f_nw);
    my_d = MOM_W'(item_i.f_n) + MOM_W'(item_i.f_ne) + MOM_W'(item_i.f_nw)
         - MOM_W'(item_i.f_se) - MOM_W'(item_i.f_s) - MOM_W'(item_i.f_sw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
      vld_q  <= '0;
    end else begin
      if (relax_rate_we_i) begin
        rate_q <= relax_rate_i;
      end
      vld_q <= {vld_q[TOTAL-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= item_i;
    rho_q <= rho_d;
    mx_q  <= mx_d;
    my_q  <= my_d;

    fd_q[0]   <= in_q;
    rhod_q[0] <= rho_q;
    for (int i = 1; i < DLY_A; i++) begin
      fd_q[i]   <= fd_q[i-1];
      rhod_q[i] <= rhod_q[i-1];
    end

    sqx_q <= ux * ux;
    sqy_q <= uy * uy;
    ux1_q <= ux;
    uy1_q <= uy;
    uu_q  <= UU_W'(sqx_q) + UU_W'(sqy_q);
    ux2_q <= ux1_q;
    uy2_q <= uy1_q;

    od_rho_q[0] <= rhod_q[DLY_A-1];
    od_ux_q[0]  <= ux2_q;
    od_uy_q[0]  <= uy2_q;
    for (int i = 1; i < LANE_LAT; i++) begin
      od_rho_q[i] <= od_rho_q[i-1];
      od_ux_q[i]  <= od_ux_q[i-1];
      od_uy_q[i]  <= od_uy_q[i-1];
    end

    result_q <= out_t'({g_flat, od_rho_q[LANE_LAT-1], od_ux_q[LANE_LAT-1],
                        od_uy_q[LANE_LAT-1]});
  end

  lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .num_i (mx_q),
    .den_i (rho_q),
    .quo_o (ux)
  );

  lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .num_i (my_q),
    .den_i (rho_q),
    .quo_o (uy)
  );

  assign f_flat = fd_q[DLY_A-1];

  for (genvar k = 0; k < N_DIR; k++) begin : g_lane
    lbm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .cx_i   (CX[k]),
      .cy_i   (CY[k]),
      .wt_i   (WT[k]),
      .f_i    (f_flat[(N_DIR-1-k)*DW +: DW]),
      .rho_i  (rhod_q[DLY_A-1]),
      .ux_i   (ux2_q),
      .uy_i   (uy2_q),
      .uu_i   (uu_q),
      .rate_i (rate_q),
      .g_o    (g[k])
    );
    assign g_flat[(N_DIR-1-k)*DW +: DW] = g[k];
  end

  assign result_o       = result_q;
  assign result_valid_o = vld_q[TOTAL-1];

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##TOTAL result_valid_o)
    else $error("accepted cell did not produce a result on time");

  a_no_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.density[DW-1] || result_o.density == '0)
    |-> result_o.vel_x == '0 && result_o.vel_y == '0)
    else $error("nonzero velocity for a cell without positive density");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// D2Q9 BGK collision testbench
// Drives directed cells and cells in random bursts under several relaxation
// rates, predicts each relaxed cell, its density and its velocity, and checks
// every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import lbm_pkg::*;

  localparam int  LATENCY   = 45;
  localparam int  IDLE_MAX  = 5000;
  localparam int  NUM_RAND  = 1200;
  localparam longint ONE    = 64'sd1 <<< 20;

  class cell_scoreboard;
    out_t                  expected_q[$];
    logic [RATE_W-1:0]     rate;
    int                    mismatches;
    int                    errors;
    int                    vx[9];
    int                    vy[9];
    longint                w36[9];

    function new();
      rate = RATE_RESET;
      vx = '{0, 0, 1, 1, 1, 0, -1, -1, -1};
      vy = '{0, 1, 1, 0, -1, -1, -1, 0, 1};
      w36 = '{16, 4, 1, 4, 1, 4, 1, 4, 1};
    endfunction

    function longint floor_div(longint x, longint d);
      longint q;
      q = x / d;
      if ((x % d) != 0 && x < 0) q = q - 1;
      return q;
    endfunction

    function longint clamp24(longint x);
      if (x > 64'sd8388607) return 64'sd8388607;
      if (x < -64'sd8388608) return -64'sd8388608;
      return x;
    endfunction

    function out_t relax_cell(in_t c);
      longint f[9];
      longint g[9];
      longint rho, mx, my, ux, uy, uu, cu, p2, p, t, feq, corr;
      out_t r;
      f = '{c.f_rest, c.f_n, c.f_ne, c.f_e, c.f_se, c.f_s, c.f_sw, c.f_w, c.f_nw};
      rho = 0;
      mx = 0;
      my = 0;
      ux = 0;
      uy = 0;
      for (int k = 0; k < 9; k++) begin
        rho += f[k];
        mx += vx[k] * f[k];
        my += vy[k] * f[k];
      end
      rho = clamp24(rho);
      if (rho > 0) begin
        ux = clamp24(floor_div(mx * ONE, rho));
        uy = clamp24(floor_div(my * ONE, rho));
      end
      uu = ux * ux + uy * uy;
      for (int k = 0; k < 9; k++) begin
        cu = vx[k] * ux + vy[k] * uy;
        p2 = 2 * ONE * ONE + 6 * cu * ONE + 9 * cu * cu - 3 * uu;
        p = floor_div(p2, 2 * ONE);
        t = floor_div(rho * p, ONE);
        feq = clamp24(floor_div(t * w36[k], 36));
        corr = floor_div((f[k] - feq) * longint'(rate), 64'sd1 <<< RATE_FRAC);
        g[k] = clamp24(f[k] - corr);
      end
      r.g_rest  = sample_t'(g[0]);
      r.g_n     = sample_t'(g[1]);
      r.g_ne    = sample_t'(g[2]);
      r.g_e     = sample_t'(g[3]);
      r.g_se    = sample_t'(g[4]);
      r.g_s     = sample_t'(g[5]);
      r.g_sw    = sample_t'(g[6]);
      r.g_w     = sample_t'(g[7]);
      r.g_nw    = sample_t'(g[8]);
      r.density = sample_t'(rho);
      r.vel_x   = sample_t'(ux);
      r.vel_y   = sample_t'(uy);
      return r;
    endfunction

    function void note_cell(in_t c);
      expected_q.push_back(relax_cell(c));
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      string names[12];
      names = '{"g_rest", "g_n", "g_ne", "g_e", "g_se", "g_s", "g_sw", "g_w",
                "g_nw", "density", "vel_x", "vel_y"};
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_r = expected_q.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (got[(11-i)*DW +: DW] !== exp_r[(11-i)*DW +: DW]) begin
          errors++;
          if (mismatches++ < 10)
            $display("%s mismatch: expected %0d, got %0d", names[i],
                     $signed(exp_r[(11-i)*DW +: DW]), $signed(got[(11-i)*DW +: DW]));
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  in_t                 item_i;
  logic                relax_rate_we_i;
  logic [RATE_W-1:0]   relax_rate_i;
  out_t                result_o;
  logic                result_valid_o;
  cell_scoreboard      sb;
  int                  idle_cycles;

  lbm_d2q9_bgk_collision uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .relax_rate_we_i (relax_rate_we_i),
    .relax_rate_i    (relax_rate_i),
    .result_o        (result_o),
    .result_valid_o  (result_valid_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (result_valid_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_cell(in_t c);
    start <= 1'b1;
    item_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_cell(c);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] v);
    drain();
    relax_rate_we_i <= 1'b1;
    relax_rate_i <= v;
    @(posedge clk_i);
    relax_rate_we_i <= 1'b0;
    sb.rate = v;
  endtask

  function automatic sample_t rand_sample();
    return sample_t'($urandom);
  endfunction

  function automatic in_t rand_cell();
    in_t c;
    int  w[9];
    int  spread;
    w = '{16, 4, 1, 4, 1, 4, 1, 4, 1};
    c = '0;
    if ($urandom_range(0, 3) == 0) begin
      c = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      spread = 1 << $urandom_range(8, 18);
      for (int k = 0; k < 9; k++)
        c[(8-k)*DW +: DW] = sample_t'(w[k] * ($urandom_range(0, 4 << 20) / 36)
                            + $signed($urandom_range(0, 2 * spread)) - spread);
    end
    return c;
  endfunction

  task automatic run_random(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_cell(rand_cell());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
  endtask

  task automatic run_directed();
    in_t c;
    send_cell('0);
    send_cell({9{24'h7FFFFF}});
    send_cell({9{24'h800000}});
    for (int k = 0; k < 9; k++) begin
      c = '0;
      c[(8-k)*DW +: DW] = 24'h7FFFFF;
      send_cell(c);
      c[(8-k)*DW +: DW] = 24'h800000;
      send_cell(c);
    end
    c = '0;
    c.f_rest = -24'sd1048576;
    c.f_e = 24'sd262144;
    send_cell(c);
    c = '0;
    c.f_e = 24'sd4000000;
    c.f_w = -24'sd4000000;
    send_cell(c);
    c = '0;
    c.f_rest = -24'sd8000000;
    c.f_e = 24'sd8000000;
    c.f_n = 24'sd1;
    send_cell(c);
    c = '0;
    c.f_ne = 24'sd8388607;
    c.f_sw = -24'sd8388600;
    send_cell(c);
    pause(1);
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    relax_rate_we_i = 1'b0;
    relax_rate_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(250);
    write_rate('0);
    run_directed();
    run_random(150);
    write_rate(22'd2097152);
    run_directed();
    run_random(250);
    write_rate(22'h3FFFFF);
    run_directed();
    run_random(150);
    for (int i = 0; i < 4; i++) begin
      write_rate(RATE_W'($urandom_range(0, 2097152)));
      run_random(100);
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
